/* rtl/core/hbfd_pkg.sv */
// ----------------------------------------------------------------------------
// hbfd_pkg
// Shared types, codes and defaults for the heartbeat failure detector.
// ----------------------------------------------------------------------------
package hbfd_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5;

    // input kinds
    localparam logic [1:0] KIND_MSG  = 2'd0;
    localparam logic [1:0] KIND_HB   = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // result kinds
    localparam logic [1:0] RES_MSG     = 2'd0;
    localparam logic [1:0] RES_HB      = 2'd1;
    localparam logic [1:0] RES_TICK    = 2'd2;
    localparam logic [1:0] RES_SUSPECT = 2'd3;

    // heartbeat outcomes
    localparam logic [1:0] HB_REFRESHED  = 2'd0;
    localparam logic [1:0] HB_ADDED      = 2'd1;
    localparam logic [1:0] HB_FULL       = 2'd2;
    localparam logic [1:0] HB_INCOMPLETE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic        dest_is_broadcast;
        logic        id_complete;
        logic [63:0] node_id_high;
        logic [63:0] node_id_low;
        logic [31:0] now_seconds;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        piggyback;
        logic [1:0]  heartbeat_status;
        logic        send_heartbeat;
        logic [63:0] suspect_id_high;
        logic [63:0] suspect_id_low;
        logic        last;
    } out_beat_t;

    typedef enum logic [1:0] {
        CMD_MSG,
        CMD_HB,
        CMD_TICK
    } cmd_op_t;

    // flag: piggyback decision for a message, send decision for a tick
    typedef struct packed {
        cmd_op_t     op;
        logic        flag;
        logic        complete;
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [31:0] now;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HB_SCAN,
        BK_TICK_SCAN,
        BK_FLUSH
    } bk_state_t;

endpackage

/* rtl/core/hbfd_front.sv */
// ----------------------------------------------------------------------------
// hbfd_front
// Accepts input beats, decodes the kind and settles the per-interval
// piggyback flag, then queues a command for the table engine.
// ----------------------------------------------------------------------------
module hbfd_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  hbfd_pkg::in_beat_t in_beat,
    input  logic             q_full,
    output logic             q_push,
    output hbfd_pkg::cmd_t   q_cmd
);
    import hbfd_pkg::*;

    logic sent_reg;
    logic sent_next;
    logic accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        q_cmd          = '0;
        q_cmd.complete = in_beat.id_complete;
        q_cmd.id_high  = in_beat.node_id_high;
        q_cmd.id_low   = in_beat.node_id_low;
        q_cmd.now      = in_beat.now_seconds;
        q_push         = 1'b0;
        sent_next      = sent_reg;
        unique case (in_beat.kind)
            KIND_MSG:
            begin
                q_cmd.op   = CMD_MSG;
                q_cmd.flag = !sent_reg || in_beat.dest_is_broadcast;
                q_push     = accept;
                if (accept)
                begin
                    sent_next = 1'b1;
                end
            end
            KIND_HB:
            begin
                q_cmd.op = CMD_HB;
                q_push   = accept;
            end
            KIND_TICK:
            begin
                q_cmd.op   = CMD_TICK;
                q_cmd.flag = !sent_reg;
                q_push     = accept;
                if (accept)
                begin
                    sent_next = 1'b0;
                end
            end
            default:
            begin
                q_cmd.op = CMD_MSG;   // unused kind: beat taken, nothing queued
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg <= 1'b0;
        end
        else
        begin
            sent_reg <= sent_next;
        end
    end

endmodule

/* rtl/core/hbfd_queue.sv */
// ----------------------------------------------------------------------------
// hbfd_queue
// Short command queue between the front decoder and the table engine.
// ----------------------------------------------------------------------------
module hbfd_queue
#(
    parameter int DEPTH = hbfd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hbfd_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           head_valid,
    output hbfd_pkg::cmd_t head_cmd,
    input  logic           pop
);
    import hbfd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("command queue underflow");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("command queue count lost a push");

endmodule

/* rtl/core/hbfd_back.sv */
// ----------------------------------------------------------------------------
// hbfd_back
// Table engine: scans a slot a cycle unless an eviction stalls; on heartbeats
// it refreshes or inserts, on ticks evicts expired nodes, registers results.
// ----------------------------------------------------------------------------
module hbfd_back
#(
    parameter int TABLE_DEPTH = hbfd_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  hbfd_pkg::cmd_t      cmd,
    output logic                pop,
    input  logic [15:0]         timeout,
    output logic                out_valid,
    input  logic                out_stall,
    output hbfd_pkg::out_beat_t out_beat
);
    import hbfd_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] ISSUE_END = IW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_DEPTH - 1);

    bk_state_t state_reg;
    bk_state_t state_next;

    cmd_t      cur_reg;
    cmd_t      cur_next;
    out_beat_t pend_reg;
    out_beat_t pend_next;
    out_beat_t out_reg;
    out_beat_t out_next;
    logic      out_vld_reg;
    logic      out_vld_next;

    logic [IW-1:0] issue_idx_reg;
    logic [IW-1:0] issue_idx_next;
    logic          cmp_vld_reg;
    logic          cmp_vld_next;
    logic [AW-1:0] cmp_idx_reg;
    logic [AW-1:0] cmp_idx_next;
    logic          free_found_reg;
    logic          free_found_next;
    logic [AW-1:0] free_idx_reg;
    logic [AW-1:0] free_idx_next;

    logic [TABLE_DEPTH-1:0] slot_vld_reg;
    logic [TABLE_DEPTH-1:0] slot_vld_next;

    logic [63:0] slot_hi_mem   [TABLE_DEPTH];
    logic [63:0] slot_lo_mem   [TABLE_DEPTH];
    logic [31:0] slot_seen_mem [TABLE_DEPTH];
    logic [63:0] rd_hi_reg;
    logic [63:0] rd_lo_reg;
    logic [31:0] rd_seen_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_id_en;
    logic          wr_seen_en;
    logic [AW-1:0] wr_addr;

    logic out_free;
    logic out_load;
    logic cur_slot_vld;
    logic slot_hit;
    logic expired;
    logic advance;
    logic scan_last;

    function automatic out_beat_t make_res(input logic [1:0] rk, input logic pb,
                                           input logic [1:0] hs, input logic sh,
                                           input logic [63:0] ih,
                                           input logic [63:0] il);
        out_beat_t r;
        r                  = '0;
        r.result_kind      = rk;
        r.piggyback        = pb;
        r.heartbeat_status = hs;
        r.send_heartbeat   = sh;
        r.suspect_id_high  = ih;
        r.suspect_id_low   = il;
        return r;
    endfunction

    assign out_valid = out_vld_reg;
    assign out_beat  = out_reg;
    assign out_free  = !out_vld_reg || !out_stall;
    assign rd_addr   = issue_idx_reg[AW-1:0];

    assign cur_slot_vld = slot_vld_reg[cmp_idx_reg];
    assign slot_hit     = cur_slot_vld && (rd_hi_reg == cur_reg.id_high)
                          && (rd_lo_reg == cur_reg.id_low);
    assign expired      = cur_slot_vld
                          && (({1'b0, rd_seen_reg} + {17'b0, timeout})
                              < {1'b0, cur_reg.now});
    assign scan_last    = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign advance      = !((state_reg == BK_TICK_SCAN) && cmp_vld_reg
                            && expired && !out_free);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        CMD_MSG:  state_next = BK_FLUSH;
                        CMD_HB:   state_next = cmd.complete ? BK_HB_SCAN : BK_FLUSH;
                        CMD_TICK: state_next = BK_TICK_SCAN;
                        default:  state_next = BK_IDLE;
                    endcase
                end
            end
            BK_HB_SCAN:
            begin
                if (cmp_vld_reg && (slot_hit || scan_last))
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_TICK_SCAN:
            begin
                if (advance && scan_last)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        slot_vld_next   = slot_vld_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        wr_id_en        = 1'b0;
        wr_seen_en      = 1'b0;
        wr_addr         = cmp_idx_reg;
        out_load        = 1'b0;

        if ((state_reg == BK_HB_SCAN || state_reg == BK_TICK_SCAN) && advance)
        begin
            if (issue_idx_reg != ISSUE_END)
            begin
                rd_en          = 1'b1;
                cmp_vld_next   = 1'b1;
                cmp_idx_next   = issue_idx_reg[AW-1:0];
                issue_idx_next = issue_idx_reg + 1'b1;
            end
            else
            begin
                cmp_vld_next = 1'b0;
            end
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop             = 1'b1;
                    cur_next        = cmd;
                    issue_idx_next  = '0;
                    cmp_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    unique case (cmd.op)
                        CMD_MSG:  pend_next = make_res(RES_MSG, cmd.flag, HB_REFRESHED,
                                                       1'b0, '0, '0);
                        CMD_HB:   pend_next = make_res(RES_HB, 1'b0, HB_INCOMPLETE,
                                                       1'b0, '0, '0);
                        CMD_TICK: pend_next = make_res(RES_TICK, 1'b0, HB_REFRESHED,
                                                       cmd.flag, '0, '0);
                        default:  pend_next = pend_reg;
                    endcase
                end
            end
            BK_HB_SCAN:
            begin
                if (cmp_vld_reg)
                begin
                    if (slot_hit)
                    begin
                        wr_seen_en = 1'b1;
                        pend_next  = make_res(RES_HB, 1'b0, HB_REFRESHED, 1'b0, '0, '0);
                    end
                    else
                    begin
                        if (!cur_slot_vld && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (scan_last)
                        begin
                            if (free_found_reg || !cur_slot_vld)
                            begin
                                wr_addr                = free_found_reg ? free_idx_reg
                                                                        : cmp_idx_reg;
                                wr_id_en               = 1'b1;
                                wr_seen_en             = 1'b1;
                                slot_vld_next[wr_addr] = 1'b1;
                                pend_next = make_res(RES_HB, 1'b0, HB_ADDED, 1'b0,
                                                     '0, '0);
                            end
                            else
                            begin
                                pend_next = make_res(RES_HB, 1'b0, HB_FULL, 1'b0,
                                                     '0, '0);
                            end
                        end
                    end
                end
            end
            BK_TICK_SCAN:
            begin
                if (cmp_vld_reg && expired && out_free)
                begin
                    out_load                   = 1'b1;
                    out_next                   = pend_reg;
                    out_next.last              = 1'b0;
                    pend_next                  = make_res(RES_SUSPECT, 1'b0, HB_REFRESHED,
                                                          1'b0, rd_hi_reg, rd_lo_reg);
                    slot_vld_next[cmp_idx_reg] = 1'b0;
                end
            end
            BK_FLUSH:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase

        out_vld_next = out_load || (out_vld_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            out_vld_reg    <= 1'b0;
            issue_idx_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            slot_vld_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_vld_reg    <= out_vld_next;
            issue_idx_reg  <= issue_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            slot_vld_reg   <= slot_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
    end

    // neighbour table
    always_ff @(posedge clk)
    begin
        if (wr_id_en)
        begin
            slot_hi_mem[wr_addr] <= cur_reg.id_high;
            slot_lo_mem[wr_addr] <= cur_reg.id_low;
        end
        if (wr_seen_en)
        begin
            slot_seen_mem[wr_addr] <= cur_reg.now;
        end
        if (rd_en)
        begin
            rd_hi_reg   <= slot_hi_mem[rd_addr];
            rd_lo_reg   <= slot_lo_mem[rd_addr];
            rd_seen_reg <= slot_seen_mem[rd_addr];
        end
    end

    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_reg.result_kind == RES_MSG
                         || out_reg.result_kind == RES_HB)) |-> out_reg.last)
        else $error("message or heartbeat result without last");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_vld_reg && out_stall))
        else $error("output register overwritten while stalled");

    a_tick_only_evicts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_TICK_SCAN)
        |=> ($countones(slot_vld_reg) <= $past($countones(slot_vld_reg))))
        else $error("slot became valid during tick scan");

    a_hb_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_HB_SCAN)
        |=> ($countones(slot_vld_reg) <= $past($countones(slot_vld_reg)) + 1))
        else $error("heartbeat filled more than one slot");

endmodule

/* rtl/core/heartbeat_failure_detector.sv */
// ----------------------------------------------------------------------------
// heartbeat_failure_detector
// Piggyback decisions, neighbour last-seen table and timeout-based suspicion.
// ----------------------------------------------------------------------------
// Input beats are decoded and queued (QUEUE_DEPTH entries), so the input side
// keeps accepting while the table engine works, until the queue is full. The
// engine serves one command at a time. A complete heartbeat or a tick runs a
// scan that reads one slot per cycle from the neighbour table while no
// eviction waits on a stalled output; a refresh ends the scan at the matching
// slot. Output stalls add to a tick's time, one suspect notice per evicted
// node. The tick summary comes first and last marks the final result of
// every queued input beat. Write timeout_seconds via cfg_wr_en/cfg_wr_data
// only while no results are outstanding.
// ----------------------------------------------------------------------------
module heartbeat_failure_detector
#(
    parameter int TABLE_DEPTH = hbfd_pkg::TABLE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = hbfd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  hbfd_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_stall,
    output hbfd_pkg::out_beat_t out_beat
);
    import hbfd_pkg::*;

    logic [15:0] timeout_reg;
    logic [15:0] timeout_next;

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic head_valid;
    cmd_t head_cmd;
    logic head_pop;

    assign timeout_next = cfg_wr_en ? cfg_wr_data : timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    hbfd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_beat  (in_beat),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    hbfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (head_pop)
    );

    hbfd_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .pop       (head_pop),
        .timeout   (timeout_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

endmodule
